### rtl/lccs_pkg.sv
// Shared constants, codes and inter-module request types for the collision search block.
package lccs_pkg;

  localparam int SEQ_LEN    = 64;
  localparam int TABLE_CNT  = 16;
  localparam int BUCKET_CNT = 64;

  localparam int OP_W    = 2;
  localparam int TAB_W   = 4;
  localparam int BKT_W   = 6;
  localparam int SLOT_W  = $clog2(SEQ_LEN);
  localparam int KEY_W   = 6;
  localparam int RNG_W   = 7;
  localparam int CNT_W   = 7;

  localparam int MEM_DEPTH = TABLE_CNT * SEQ_LEN;
  localparam int RNG_DEPTH = TABLE_CNT * BUCKET_CNT;
  localparam int MADDR_W   = TAB_W + SLOT_W;
  localparam int RADDR_W   = TAB_W + BKT_W;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [RNG_W-1:0] SLOT_LIM  = RNG_W'(SEQ_LEN);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_MEMBER = 2'd0,
    OP_LOAD_RANGE  = 2'd1,
    OP_CLEAR       = 2'd2,
    OP_QUERY       = 2'd3
  } op_t;

  typedef logic [1:0] mark_t;
  localparam mark_t MARK_UNSEEN = 2'd0;
  localparam mark_t MARK_ONCE   = 2'd1;
  localparam mark_t MARK_DONE   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANGE,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               mem_we;
    logic               mem_re;
    logic [MADDR_W-1:0] mem_addr;
    logic [KEY_W-1:0]   mem_wdata;
    logic               rng_we;
    logic               rng_re;
    logic [RADDR_W-1:0] rng_addr;
    logic [RNG_W-1:0]   rng_first;
    logic [RNG_W-1:0]   rng_after;
  } tbl_req_t;

  typedef struct packed {
    logic             rd_en;
    logic [KEY_W-1:0] rd_addr;
    logic             wr_en;
    logic [KEY_W-1:0] wr_addr;
    mark_t            wr_data;
    logic             hold;
    logic             clear;
  } mark_req_t;

endpackage

### rtl/lccs_tables.sv
// Bucket member list memory and bucket range memory, both with registered read outputs.
module lccs_tables import lccs_pkg::*; (
  input  logic                 clk,
  input  tbl_req_t             req,
  output logic [KEY_W-1:0]     member_key,
  output logic [RNG_W-1:0]     range_first,
  output logic [RNG_W-1:0]     range_after
);

  logic [KEY_W-1:0]   member_mem [MEM_DEPTH];
  logic [2*RNG_W-1:0] range_mem  [RNG_DEPTH];
  logic [KEY_W-1:0]   member_q_r;
  logic [2*RNG_W-1:0] range_q_r;

  always_ff @(posedge clk) begin
    if (req.mem_we) begin
      member_mem[req.mem_addr] <= req.mem_wdata;
    end
    if (req.mem_re) begin
      member_q_r <= member_mem[req.mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rng_we) begin
      range_mem[req.rng_addr] <= {req.rng_first, req.rng_after};
    end
    if (req.rng_re) begin
      range_q_r <= range_mem[req.rng_addr];
    end
  end

  assign member_key  = member_q_r;
  assign range_first = range_q_r[2*RNG_W-1:RNG_W];
  assign range_after = range_q_r[RNG_W-1:0];

endmodule

### rtl/lccs_marks.sv
// Per-key hit mark memory with valid bits for clearing and write-to-read forwarding.
module lccs_marks import lccs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mark_req_t req,
  output mark_t     rd_mark
);

  mark_t              mark_mem [SEQ_LEN];
  mark_t              mem_q_r;
  logic [KEY_W-1:0]   addr_q_r;
  logic [SEQ_LEN-1:0] vld_r;
  logic               fwd_v_r;
  logic [KEY_W-1:0]   fwd_addr_r;
  mark_t              fwd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mark_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q_r  <= mark_mem[req.rd_addr];
      addr_q_r <= req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      fwd_v_r <= 1'b0;
    end else if (!req.hold) begin
      fwd_v_r <= req.wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!req.hold) begin
      fwd_addr_r <= req.wr_addr;
      fwd_data_r <= req.wr_data;
    end
  end

  always_comb begin
    if (fwd_v_r && (fwd_addr_r == addr_q_r)) begin
      rd_mark = fwd_data_r;
    end else if (vld_r[addr_q_r]) begin
      rd_mark = mem_q_r;
    end else begin
      rd_mark = MARK_UNSEEN;
    end
  end

endmodule

### rtl/lsh_collision_candidate_search.sv
// Top level: command decode, bucket walk pipeline, report holding and output register.
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid in_ready in_op in_table_req in_bucket_id   | input beat
//          | in_position in_key_index in_range_first ..._after  |
//  out     | out_valid out_ready out_selected_index             | result beat
//          | out_selected_valid out_total_selected out_last     |
//
//  Loads and clear complete on acceptance. A query runs one range read, then one member per
//  cycle, unless stalled, through member read, mark read and mark write, pipeline drain,
//  then the closing beat. Output stalls hold the walk only when a report meets a full output
//  register and a held report. Reset clears the marks, the running total and all control
//  state; member and range memories hold nothing defined until loaded.
module lsh_collision_candidate_search import lccs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [TAB_W-1:0]   in_table_req,
  input  logic [BKT_W-1:0]   in_bucket_id,
  input  logic [SLOT_W-1:0]  in_position,
  input  logic [KEY_W-1:0]   in_key_index,
  input  logic [RNG_W-1:0]   in_range_first,
  input  logic [RNG_W-1:0]   in_range_after,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KEY_W-1:0]   out_selected_index,
  output logic               out_selected_valid,
  output logic [CNT_W-1:0]   out_total_selected,
  output logic               out_last
);

  state_t             state_r, state_nxt;
  logic [RNG_W-1:0]   slot_r, slot_nxt;
  logic [RNG_W-1:0]   end_r, end_nxt;
  logic [TAB_W-1:0]   tbl_r;
  logic               qok_r;
  logic               b_v_r, c_v_r;
  logic [KEY_W-1:0]   c_key_r;
  logic               p_v_r;
  logic [KEY_W-1:0]   p_idx_r;
  logic [CNT_W-1:0]   p_tot_r;
  logic               o_valid_r;
  logic [KEY_W-1:0]   o_idx_r;
  logic               o_sel_r;
  logic [CNT_W-1:0]   o_tot_r;
  logic               o_last_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_inc;

  op_t                op;
  logic               accept;
  logic               tbl_ok, bkt_ok, pos_ok, key_ok;
  logic               issue;
  logic               walk_done;
  logic               stall;
  logic               report;
  logic               c_fire;
  logic               o_free;
  logic               push_walk, push_fin;
  logic [RNG_W-1:0]   after_c;

  tbl_req_t           treq;
  mark_req_t          mreq;
  logic [KEY_W-1:0]   member_key;
  logic [RNG_W-1:0]   rng_first, rng_after;
  mark_t              mark;

  assign op       = op_t'(in_op);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign tbl_ok   = int'(in_table_req) < TABLE_CNT;
  assign bkt_ok   = int'(in_bucket_id) < BUCKET_CNT;
  assign pos_ok   = int'(in_position) < SEQ_LEN;
  assign key_ok   = int'(c_key_r) < SEQ_LEN;

  assign report    = c_v_r && key_ok && (mark == MARK_ONCE);
  assign o_free    = !o_valid_r || out_ready;
  assign stall     = report && p_v_r && o_valid_r && !out_ready;
  assign c_fire    = c_v_r && !stall;
  assign push_walk = c_fire && report && p_v_r;
  assign push_fin  = (state_r == ST_FINISH) && o_free;
  assign count_inc = (count_r != CNT_MAX) ? count_r + CNT_W'(1) : count_r;

  assign issue     = (state_r == ST_WALK) && (slot_r < end_r) && !stall;
  assign walk_done = (slot_r >= end_r) && !b_v_r && !c_v_r;
  assign after_c   = (rng_after > SLOT_LIM) ? SLOT_LIM : rng_after;

  always_comb begin
    treq.mem_we    = accept && (op == OP_LOAD_MEMBER) && tbl_ok && pos_ok;
    treq.mem_re    = (state_r == ST_WALK) && !stall;
    treq.mem_addr  = (state_r == ST_WALK) ? {tbl_r, slot_r[SLOT_W-1:0]}
                                          : {in_table_req, in_position};
    treq.mem_wdata = in_key_index;
    treq.rng_we    = accept && (op == OP_LOAD_RANGE) && tbl_ok && bkt_ok;
    treq.rng_re    = accept && (op == OP_QUERY);
    treq.rng_addr  = {in_table_req, in_bucket_id};
    treq.rng_first = in_range_first;
    treq.rng_after = in_range_after;
  end

  always_comb begin
    mreq.rd_en   = b_v_r && !stall;
    mreq.rd_addr = member_key;
    mreq.wr_en   = c_fire && key_ok && ((mark == MARK_UNSEEN) || (mark == MARK_ONCE));
    mreq.wr_addr = c_key_r;
    mreq.wr_data = (mark == MARK_UNSEEN) ? MARK_ONCE : MARK_DONE;
    mreq.hold    = stall;
    mreq.clear   = accept && (op == OP_CLEAR);
  end

  lccs_tables u_tables (
    .clk         (clk),
    .req         (treq),
    .member_key  (member_key),
    .range_first (rng_first),
    .range_after (rng_after)
  );

  lccs_marks u_marks (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .rd_mark (mark)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    end_nxt   = end_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (op == OP_QUERY)) begin
          state_nxt = ST_RANGE;
        end
      end
      ST_RANGE: begin
        slot_nxt = rng_first;
        end_nxt  = after_c;
        state_nxt = qok_r ? ST_WALK : ST_FINISH;
      end
      ST_WALK: begin
        if (issue) begin
          slot_nxt = slot_r + RNG_W'(1);
        end
        if (walk_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (o_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    end_r  <= end_nxt;
    if (accept && (op == OP_QUERY)) begin
      tbl_r <= in_table_req;
      qok_r <= tbl_ok && bkt_ok;
    end
  end

  // advance the walk pipeline unless a report is blocked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (!stall) begin
      b_v_r <= issue;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && b_v_r) begin
      c_key_r <= member_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || mreq.clear) begin
      count_r <= '0;
    end else if (c_fire && report) begin
      count_r <= count_inc;
    end
  end

  // hold the latest report until the next one or the end of the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (c_fire && report) begin
      p_v_r <= 1'b1;
    end else if (push_fin) begin
      p_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_fire && report) begin
      p_idx_r <= c_key_r;
      p_tot_r <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (push_walk || push_fin) begin
      o_valid_r <= 1'b1;
    end else if (out_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_walk) begin
      o_idx_r  <= p_idx_r;
      o_sel_r  <= 1'b1;
      o_tot_r  <= p_tot_r;
      o_last_r <= 1'b0;
    end else if (push_fin) begin
      o_idx_r  <= p_v_r ? p_idx_r : '0;
      o_sel_r  <= p_v_r;
      o_tot_r  <= p_v_r ? p_tot_r : count_r;
      o_last_r <= 1'b1;
    end
  end

  assign out_valid          = o_valid_r;
  assign out_selected_index = o_idx_r;
  assign out_selected_valid = o_sel_r;
  assign out_total_selected = o_tot_r;
  assign out_last           = o_last_r;

endmodule

### tb/sv/lccs_result_checker.sv
// Checker for the collision search block: mirrors state from command beats, compares results.
`timescale 1ns / 100ps
module lccs_result_checker import lccs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [TAB_W-1:0]  in_table_req,
  input  logic [BKT_W-1:0]  in_bucket_id,
  input  logic [SLOT_W-1:0] in_position,
  input  logic [KEY_W-1:0]  in_key_index,
  input  logic [RNG_W-1:0]  in_range_first,
  input  logic [RNG_W-1:0]  in_range_after,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KEY_W-1:0]  out_selected_index,
  input  logic              out_selected_valid,
  input  logic [CNT_W-1:0]  out_total_selected,
  input  logic              out_last,
  output int                mismatches,
  output int                pending_results,
  output int                reported_keys,
  output int                empty_replies
);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             found;
    logic [CNT_W-1:0] total;
    logic             last;
  } report_t;

  mark_t            hit_marks    [SEQ_LEN];
  logic [KEY_W-1:0] member_keys  [TABLE_CNT][SEQ_LEN];
  logic [RNG_W-1:0] bucket_first [TABLE_CNT][BUCKET_CNT];
  logic [RNG_W-1:0] bucket_after [TABLE_CNT][BUCKET_CNT];
  logic [CNT_W-1:0] keys_reported;
  report_t          expected_reports [$];

  task automatic walk_bucket(input int tbl, input int bkt);
    report_t          held;
    logic             have_held;
    int               stop;
    logic [KEY_W-1:0] k;
    have_held = 1'b0;
    held = '0;
    stop = (bucket_after[tbl][bkt] > SLOT_LIM) ? SEQ_LEN : int'(bucket_after[tbl][bkt]);
    for (int s = int'(bucket_first[tbl][bkt]); s < stop; s++) begin
      k = member_keys[tbl][s];
      if (hit_marks[k] == MARK_UNSEEN) begin
        hit_marks[k] = MARK_ONCE;
      end else if (hit_marks[k] == MARK_ONCE) begin
        hit_marks[k] = MARK_DONE;
        if (keys_reported != CNT_MAX) keys_reported++;
        if (have_held) expected_reports.push_back(held);
        held.key = k;
        held.found = 1'b1;
        held.total = keys_reported;
        held.last = 1'b0;
        have_held = 1'b1;
      end
    end
    if (!have_held) begin
      held.key = '0;
      held.found = 1'b0;
      held.total = keys_reported;
    end
    held.last = 1'b1;
    expected_reports.push_back(held);
  endtask

  always @(posedge clk) begin : track
    report_t want;
    if (!rst_n) begin
      foreach (hit_marks[i]) hit_marks[i] = MARK_UNSEEN;
      keys_reported = '0;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result beat: key %0d valid %0b total %0d last %0b",
                     $realtime, out_selected_index, out_selected_valid, out_total_selected,
                     out_last);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (out_selected_index !== want.key || out_selected_valid !== want.found ||
              out_total_selected !== want.total || out_last !== want.last) begin
            if (mismatches < 10)
              $display({"%0t: result mismatch: expected key %0d valid %0b total %0d last %0b,",
                        " got key %0d valid %0b total %0d last %0b"},
                       $realtime, want.key, want.found, want.total, want.last,
                       out_selected_index, out_selected_valid, out_total_selected, out_last);
            mismatches++;
          end
          if (out_selected_valid) reported_keys++;
          else empty_replies++;
        end
      end
      if (in_valid && in_ready) begin
        case (op_t'(in_op))
          OP_LOAD_MEMBER: member_keys[in_table_req][in_position] = in_key_index;
          OP_LOAD_RANGE: begin
            bucket_first[in_table_req][in_bucket_id] = in_range_first;
            bucket_after[in_table_req][in_bucket_id] = in_range_after;
          end
          OP_CLEAR: begin
            foreach (hit_marks[i]) hit_marks[i] = MARK_UNSEEN;
            keys_reported = '0;
          end
          OP_QUERY: walk_bucket(in_table_req, in_bucket_id);
        endcase
      end
    end
    pending_results = expected_reports.size();
  end

endmodule

### tb/sv/lsh_collision_candidate_search_tb.sv
// Testbench top for the collision search block: command stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps
module lsh_collision_candidate_search_tb;
  import lccs_pkg::*;

  localparam int TOTAL_BEATS  = 430;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 100;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_op;
  logic [TAB_W-1:0]  in_table_req;
  logic [BKT_W-1:0]  in_bucket_id;
  logic [SLOT_W-1:0] in_position;
  logic [KEY_W-1:0]  in_key_index;
  logic [RNG_W-1:0]  in_range_first;
  logic [RNG_W-1:0]  in_range_after;
  logic              out_valid;
  logic              out_ready;
  logic [KEY_W-1:0]  out_selected_index;
  logic              out_selected_valid;
  logic [CNT_W-1:0]  out_total_selected;
  logic              out_last;

  int mismatches;
  int pending_results;
  int reported_keys;
  int empty_replies;

  logic mem_loaded [TABLE_CNT][SEQ_LEN];
  logic rng_loaded [TABLE_CNT][BUCKET_CNT];
  int   probe_list [$];
  int   beats_sent;
  int   queries_sent;
  int   clears_sent;
  int   sender_steady;

  lsh_collision_candidate_search dut (.*);

  lccs_result_checker report_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input op_t op, input int tbl, input int bkt, input int slot,
                           input int key, input int first, input int after);
    int gap;
    gap = 0;
    if (sender_steady > 0) sender_steady--;
    else if ($urandom_range(0, 99) < 2) sender_steady = $urandom_range(20, 80);
    else if ($urandom_range(0, 99) < 40) gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    in_table_req = (op == OP_CLEAR) ? TAB_W'($urandom_range(0, TABLE_CNT - 1)) : TAB_W'(tbl);
    in_bucket_id = (op == OP_LOAD_RANGE || op == OP_QUERY) ?
                   BKT_W'(bkt) : BKT_W'($urandom_range(0, BUCKET_CNT - 1));
    in_position = (op == OP_LOAD_MEMBER) ? SLOT_W'(slot) : SLOT_W'($urandom_range(0, SEQ_LEN - 1));
    in_key_index = (op == OP_LOAD_MEMBER) ? KEY_W'(key) : KEY_W'($urandom_range(0, SEQ_LEN - 1));
    in_range_first = (op == OP_LOAD_RANGE) ? RNG_W'(first) : RNG_W'($urandom_range(0, SEQ_LEN));
    in_range_after = (op == OP_LOAD_RANGE) ? RNG_W'(after) : RNG_W'($urandom_range(0, SEQ_LEN));
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
    case (op)
      OP_LOAD_MEMBER: mem_loaded[tbl][slot] = 1'b1;
      OP_LOAD_RANGE: begin
        if (!rng_loaded[tbl][bkt]) probe_list.push_back(tbl * BUCKET_CNT + bkt);
        rng_loaded[tbl][bkt] = 1'b1;
      end
      OP_CLEAR: clears_sent++;
      OP_QUERY: queries_sent++;
    endcase
  endtask

  // hold the sender until every expected beat has come back
  task automatic hold_until_drained();
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic fill_and_probe();
    int tbl;
    int bkt;
    int len;
    int start;
    int base;
    int spread;
    int first;
    int after;
    tbl = $urandom_range(0, TABLE_CNT - 1);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    start = $urandom_range(0, SEQ_LEN - len);
    base = $urandom_range(0, SEQ_LEN - 1);
    spread = $urandom_range(0, 7);
    if ($urandom_range(0, 4) == 0) send_beat(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    for (int s = start; s < start + len; s++)
      send_beat(OP_LOAD_MEMBER, tbl, 0, s, (base + $urandom_range(0, spread)) % SEQ_LEN, 0, 0);
    first = start;
    after = start + len;
    if ($urandom_range(0, 3) == 0) begin
      first = $urandom_range(start, start + len);
      after = $urandom_range(first, start + len);
    end
    bkt = $urandom_range(0, BUCKET_CNT - 1);
    send_beat(OP_LOAD_RANGE, tbl, bkt, 0, 0, first, after);
    repeat ($urandom_range(1, 3)) send_beat(OP_QUERY, tbl, bkt, 0, 0, 0, 0);
  endtask

  task automatic stray_beat();
    int  roll;
    int  tbl;
    int  first;
    int  after;
    int  entry;
    bit  covered;
    roll = $urandom_range(0, 99);
    tbl = $urandom_range(0, TABLE_CNT - 1);
    if (roll < 20) begin
      send_beat(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    end else if (roll < 45) begin
      send_beat(OP_LOAD_MEMBER, tbl, 0, $urandom_range(0, SEQ_LEN - 1),
                $urandom_range(0, SEQ_LEN - 1), 0, 0);
    end else if (roll < 70) begin
      first = $urandom_range(0, SEQ_LEN);
      after = $urandom_range(0, SEQ_LEN);
      covered = 1'b1;
      for (int s = first; s < after && s < SEQ_LEN; s++)
        if (!mem_loaded[tbl][s]) covered = 1'b0;
      // shrink to an empty bucket rather than walk unloaded slots
      if (!covered) after = $urandom_range(0, first);
      send_beat(OP_LOAD_RANGE, tbl, $urandom_range(0, BUCKET_CNT - 1), 0, 0, first, after);
    end else begin
      entry = probe_list[$urandom_range(0, probe_list.size() - 1)];
      send_beat(OP_QUERY, entry / BUCKET_CNT, entry % BUCKET_CNT, 0, 0, 0, 0);
    end
  endtask

  task automatic fill_whole_table();
    int tbl;
    int bkt;
    int mask;
    tbl = $urandom_range(0, TABLE_CNT - 1);
    bkt = $urandom_range(0, BUCKET_CNT - 1);
    mask = $urandom_range(0, SEQ_LEN - 1);
    for (int s = 0; s < SEQ_LEN; s++) send_beat(OP_LOAD_MEMBER, tbl, 0, s, s ^ mask, 0, 0);
    send_beat(OP_LOAD_RANGE, tbl, bkt, 0, 0, 0, SEQ_LEN);
    send_beat(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_beat(OP_QUERY, tbl, bkt, 0, 0, 0, 0);
    send_beat(OP_QUERY, tbl, bkt, 0, 0, 0, 0);
    hold_until_drained();
  endtask

  initial begin : result_pacing
    int hold_cycles;
    int steady_cycles;
    hold_cycles = 0;
    steady_cycles = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = 1'b1;
        if (steady_cycles > 0) steady_cycles--;
        else if ($urandom_range(0, 99) < 3) steady_cycles = $urandom_range(20, 150);
        else if ($urandom_range(0, 99) < 30) hold_cycles = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int sweeps_done;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_CLEAR;
    in_table_req = '0;
    in_bucket_id = '0;
    in_position = '0;
    in_key_index = '0;
    in_range_first = '0;
    in_range_after = '0;
    beats_sent = 0;
    queries_sent = 0;
    clears_sent = 0;
    sender_steady = 0;
    sweeps_done = 0;
    foreach (mem_loaded[t, s]) mem_loaded[t][s] = 1'b0;
    foreach (rng_loaded[t, b]) rng_loaded[t][b] = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    send_beat(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_beat(OP_LOAD_MEMBER, 15, 0, 63, 63, 0, 0);
    send_beat(OP_LOAD_MEMBER, 15, 0, 62, 63, 0, 0);
    send_beat(OP_LOAD_MEMBER, 15, 0, 0, 0, 0, 0);
    send_beat(OP_LOAD_RANGE, 15, 63, 0, 0, 62, SEQ_LEN);
    send_beat(OP_QUERY, 15, 63, 0, 0, 0, 0);
    send_beat(OP_QUERY, 15, 63, 0, 0, 0, 0);
    send_beat(OP_LOAD_RANGE, 15, 0, 0, 0, SEQ_LEN, SEQ_LEN);
    send_beat(OP_QUERY, 15, 0, 0, 0, 0, 0);
    send_beat(OP_LOAD_RANGE, 0, 1, 0, 0, 5, 3);
    send_beat(OP_QUERY, 0, 1, 0, 0, 0, 0);
    send_beat(OP_LOAD_RANGE, 15, 62, 0, 0, 0, 1);
    send_beat(OP_QUERY, 15, 62, 0, 0, 0, 0);
    send_beat(OP_QUERY, 15, 62, 0, 0, 0, 0);
    send_beat(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_beat(OP_QUERY, 15, 63, 0, 0, 0, 0);
    send_beat(OP_LOAD_MEMBER, 15, 0, 61, 63, 0, 0);
    send_beat(OP_LOAD_RANGE, 15, 61, 0, 0, 61, SEQ_LEN);
    send_beat(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_beat(OP_QUERY, 15, 61, 0, 0, 0, 0);
    send_beat(OP_LOAD_RANGE, 0, 0, 0, 0, 0, 0);
    send_beat(OP_QUERY, 0, 0, 0, 0, 0, 0);
    send_beat(OP_LOAD_RANGE, 15, 63, 0, 0, SEQ_LEN, 0);
    send_beat(OP_QUERY, 15, 63, 0, 0, 0, 0);

    while (beats_sent < TOTAL_BEATS) begin
      if (sweeps_done < 2 && beats_sent > 150 * (sweeps_done + 1)) begin
        fill_whole_table();
        sweeps_done++;
      end else if ($urandom_range(0, 99) < 70) begin
        fill_and_probe();
      end else begin
        stray_beat();
      end
      if ($urandom_range(0, 29) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d command beats, %0d of them queries and %0d clears.",
             beats_sent, queries_sent, clears_sent);
    $display("Checked %0d reported keys and %0d empty query replies.",
             reported_keys, empty_replies);
    if (mismatches == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/lccs_pkg.sv
rtl/lccs_tables.sv
rtl/lccs_marks.sv
rtl/lsh_collision_candidate_search.sv
tb/sv/lccs_result_checker.sv
tb/sv/lsh_collision_candidate_search_tb.sv
